FILE: design/min_cost_k_jump_dp_macros.svh
// Assertion macros used by the checker of the jump-cost block.
`ifndef MIN_COST_K_JUMP_DP_MACROS_SVH
`define MIN_COST_K_JUMP_DP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCKJ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MCKJ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/mckj_pkg.sv
// Shared types and fixed field widths of the jump-cost block.
package mckj_pkg;

  localparam int HEIGHT_W = 16;
  localparam int COST_W   = 32;
  localparam int REACH_W  = 5;

  localparam logic [REACH_W-1:0] REACH_RESET = 5'd2;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_e;

endpackage

FILE: design/mckj_ifs.sv
// Valid/ready channel interfaces for configuration, input and result items.
interface mckj_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mckj_pkg::REACH_W-1:0]      jump_reach;
  modport source (output valid, jump_reach, input ready);
  modport sink (input valid, jump_reach, output ready);
endinterface

interface mckj_in_if;
  logic                              valid;
  logic                              ready;
  logic [mckj_pkg::HEIGHT_W-1:0]     height;
  logic                              last;
  modport source (output valid, height, last, input ready);
  modport sink (input valid, height, last, output ready);
endinterface

interface mckj_out_if;
  logic                              valid;
  logic                              ready;
  logic [mckj_pkg::COST_W-1:0]       min_cost;
  logic                              saturated;
  logic                              last_res;
  modport source (output valid, min_cost, saturated, last_res, input ready);
  modport sink (input valid, min_cost, saturated, last_res, output ready);
endinterface

FILE: design/mckj_cand.sv
// Candidate unit: absolute height difference plus earlier cost, saturating, registered.
module mckj_cand #(
  parameter int HEIGHT_BITS = 16,
  parameter int COST_BITS   = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [HEIGHT_BITS-1:0] height_i,
  input  logic [HEIGHT_BITS-1:0] prev_height_i,
  input  logic [COST_BITS-1:0]   prev_cost_i,
  output logic                   valid_o,
  output logic [COST_BITS-1:0]   cost_o
);

  localparam int SUM_W = ((COST_BITS > HEIGHT_BITS) ? COST_BITS : HEIGHT_BITS) + 1;
  localparam logic [SUM_W-1:0] LIMIT_W = SUM_W'({COST_BITS{1'b1}});

  logic [HEIGHT_BITS-1:0] diff;
  logic [SUM_W-1:0]       sum;
  logic [COST_BITS-1:0]   cost_d, cost_q;
  logic                   valid_q;

  always_comb begin
    if (height_i >= prev_height_i) begin
      diff = height_i - prev_height_i;
    end else begin
      diff = prev_height_i - height_i;
    end
    sum = SUM_W'(prev_cost_i) + SUM_W'(diff);
    if (sum > LIMIT_W) begin
      cost_d = '1;
    end else begin
      cost_d = sum[COST_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cost_q <= cost_d;
  end

  assign valid_o = valid_q;
  assign cost_o  = cost_q;

endmodule

FILE: design/min_cost_k_jump_dp.sv
// Least-energy staircase climb with jumps of up to k steps, one step height per transaction.
//
// Channels: cfg_i writes jump_reach (k) and is always ready; a value of 0 acts as 1 and a
// value above MAX_K acts as MAX_K. in_i carries one step height and a last flag per
// transaction; out_o returns exactly one result per input: the least total cost to reach
// that step, a saturation flag and the echoed last flag.
// Timing: an item is accepted only while the block is idle. It is then scanned against span
// earlier entries, where span = min(k, steps seen so far in the sequence), and its result
// is loaded into the output register; the first step of a sequence skips the scan. The
// next input is accepted in the cycle after that load. The scan walks the history memory,
// one earlier step per cycle through a single candidate adder and comparator.
// The history of the last MAX_K heights and costs lives in one synchronous memory; the new
// entry is written after the scan, so reads and the write never touch the same cycle.
// Reset clears the sequence count, the ring pointer and the output valid flag and sets k
// to 2; the memory is not cleared, since only entries of the current sequence are read.
// When the receiver stalls, the finished result waits in the output register and the
// next input can already be accepted and scanned; its result waits until the slot frees.
// After a transaction with last set, the next step starts a new sequence at cost 0.
module min_cost_k_jump_dp #(
  parameter int MAX_K       = 16,
  parameter int HEIGHT_BITS = 16,
  parameter int COST_BITS   = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mckj_cfg_if.sink     cfg_i,
  mckj_in_if.sink      in_i,
  mckj_out_if.source   out_o
);

  localparam int AW       = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CW       = $clog2(MAX_K + 1);
  localparam int MW       = HEIGHT_BITS + COST_BITS;
  localparam int OUT_W    = mckj_pkg::COST_W;
  localparam logic [AW-1:0] LAST_IDX  = AW'(MAX_K - 1);
  localparam logic [CW-1:0] MAX_K_C   = CW'(MAX_K);
  localparam logic [COST_BITS-1:0] LIMIT = '1;

  mckj_pkg::state_e state_q, state_d;

  logic [mckj_pkg::REACH_W-1:0] reach_q;
  logic [CW-1:0]          reach_eff;
  logic [CW-1:0]          span;
  logic [CW-1:0]          steps_q, steps_d;
  logic [CW-1:0]          rem_q, rem_d;
  logic [AW-1:0]          wr_pos_q, wr_pos_d;
  logic [AW-1:0]          rd_ptr_q, rd_ptr_d;
  logic [HEIGHT_BITS-1:0] h_q, h_d;
  logic                   last_q, last_d;
  logic [COST_BITS-1:0]   best_q, best_d;
  logic                   rd_vld_q;

  logic [MW-1:0]          mem [MAX_K];
  logic [MW-1:0]          rd_data_q;

  logic                   in_acc;
  logic                   issue;
  logic                   commit;
  logic                   cand_vld;
  logic [COST_BITS-1:0]   cand_cost;

  logic                   out_valid_q, out_valid_d;
  logic [OUT_W-1:0]       out_cost_q;
  logic                   out_sat_q;
  logic                   out_last_q;

  // Configuration port.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reach_q <= mckj_pkg::REACH_RESET;
    end else if (cfg_i.valid) begin
      reach_q <= cfg_i.jump_reach;
    end
  end

  always_comb begin
    priority if (reach_q == '0) begin
      reach_eff = CW'(1);
    end else if (32'(reach_q) > 32'(MAX_K)) begin
      reach_eff = MAX_K_C;
    end else begin
      reach_eff = CW'(reach_q);
    end
    span = (steps_q < reach_eff) ? steps_q : reach_eff;
  end

  assign in_i.ready = (state_q == mckj_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign issue      = (state_q == mckj_pkg::ST_SCAN) && (rem_q != '0);
  assign commit     = (state_q == mckj_pkg::ST_WRITE) && (!out_valid_q || out_o.ready);

  // History memory: height and cost of each step, read in the cycle after the address.
  always_ff @(posedge clk_i) begin
    if (commit) begin
      mem[wr_pos_q] <= {h_q, best_q};
    end
    rd_data_q <= mem[rd_ptr_q];
  end

  mckj_cand #(
    .HEIGHT_BITS (HEIGHT_BITS),
    .COST_BITS   (COST_BITS)
  ) u_cand (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (rd_vld_q),
    .height_i      (h_q),
    .prev_height_i (rd_data_q[MW-1:COST_BITS]),
    .prev_cost_i   (rd_data_q[COST_BITS-1:0]),
    .valid_o       (cand_vld),
    .cost_o        (cand_cost)
  );

  always_comb begin
    state_d  = state_q;
    steps_d  = steps_q;
    rem_d    = rem_q;
    wr_pos_d = wr_pos_q;
    rd_ptr_d = rd_ptr_q;
    h_d      = h_q;
    last_d   = last_q;
    best_d   = best_q;

    unique case (state_q)
      mckj_pkg::ST_IDLE: begin
        if (in_acc) begin
          h_d      = HEIGHT_BITS'(in_i.height);
          last_d   = in_i.last;
          rem_d    = span;
          rd_ptr_d = (wr_pos_q == '0) ? LAST_IDX : wr_pos_q - AW'(1);
          // The first step of a sequence has no predecessor and costs nothing.
          best_d   = (span == '0) ? '0 : LIMIT;
          state_d  = (span == '0) ? mckj_pkg::ST_WRITE : mckj_pkg::ST_SCAN;
        end
      end
      mckj_pkg::ST_SCAN: begin
        if (issue) begin
          rem_d    = rem_q - CW'(1);
          rd_ptr_d = (rd_ptr_q == '0) ? LAST_IDX : rd_ptr_q - AW'(1);
        end
        if (cand_vld && (cand_cost < best_q)) begin
          best_d = cand_cost;
        end
        // Leave only when no read or candidate is still in flight.
        if (!issue && !rd_vld_q && !cand_vld) begin
          state_d = mckj_pkg::ST_WRITE;
        end
      end
      mckj_pkg::ST_WRITE: begin
        if (commit) begin
          if (last_q) begin
            wr_pos_d = '0;
            steps_d  = '0;
          end else begin
            wr_pos_d = (wr_pos_q == LAST_IDX) ? '0 : wr_pos_q + AW'(1);
            steps_d  = (steps_q == MAX_K_C) ? steps_q : steps_q + CW'(1);
          end
          state_d = mckj_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mckj_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mckj_pkg::ST_IDLE;
      steps_q  <= '0;
      rem_q    <= '0;
      wr_pos_q <= '0;
      rd_ptr_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      steps_q  <= steps_d;
      rem_q    <= rem_d;
      wr_pos_q <= wr_pos_d;
      rd_ptr_q <= rd_ptr_d;
      rd_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q    <= h_d;
    last_q <= last_d;
    best_q <= best_d;
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_cost_q <= OUT_W'(best_q);
      out_sat_q  <= (best_q == LIMIT);
      out_last_q <= last_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.min_cost  = out_cost_q;
  assign out_o.saturated = out_sat_q;
  assign out_o.last_res  = out_last_q;

endmodule

FILE: design/mckj_checker.sv
// Port-level checker for the jump-cost block and its bind to the top level.
`include "min_cost_k_jump_dp_macros.svh"

module mckj_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [mckj_pkg::COST_W-1:0]       out_min_cost,
  input logic                              out_saturated,
  input logic                              out_last_res
);

  logic in_acc;
  logic out_stall;
  logic first_q;

  assign in_acc    = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // Tracks whether the next result opens a new sequence.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (out_valid && out_ready) begin
      first_q <= out_last_res;
    end
  end

  `MCKJ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid)
  `MCKJ_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(out_min_cost))
  `MCKJ_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, !in_ready)
  `MCKJ_ASSERT_NOW(a_first_zero, clk_i, rst_ni, out_valid && first_q, (out_min_cost == '0) && !out_saturated)

endmodule

bind min_cost_k_jump_dp mckj_checker u_mckj_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_i.valid),
  .in_ready      (in_i.ready),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .out_min_cost  (out_o.min_cost),
  .out_saturated (out_o.saturated),
  .out_last_res  (out_o.last_res)
);

FILE: dv/tb_min_cost_k_jump_dp.sv
// Self-checking testbench for min_cost_k_jump_dp: staircase stimulus, cost prediction, checks.
module tb_min_cost_k_jump_dp;
  timeunit 1ns;
  timeprecision 1ps;

  class climb_cost_scoreboard;
    localparam int WINDOW = 16;
    localparam longint unsigned COST_LIMIT = (64'd1 << mckj_pkg::COST_W) - 1;

    typedef struct packed {
      logic [mckj_pkg::COST_W-1:0] min_cost;
      logic                        saturated;
      logic                        last_res;
    } climb_result_t;

    logic [mckj_pkg::HEIGHT_W-1:0] heights [WINDOW];
    logic [mckj_pkg::COST_W-1:0]   costs [WINDOW];
    int unsigned                   steps_in_run;
    int unsigned                   ring_ptr;
    logic [mckj_pkg::REACH_W-1:0]  reach;
    climb_result_t                 expected_costs [$];
    int                            errors;
    int                            results_checked;
    int                            saturated_seen;
    int                            staircases_done;

    function new();
      steps_in_run    = 0;
      ring_ptr        = 0;
      reach           = mckj_pkg::REACH_RESET;
      errors          = 0;
      results_checked = 0;
      saturated_seen  = 0;
      staircases_done = 0;
    endfunction

    function void set_reach(logic [mckj_pkg::REACH_W-1:0] k);
      reach = k;
    endfunction

    function int pending();
      return expected_costs.size();
    endfunction

    // Works out the cost of one accepted step and queues it.
    function void predict_climb_cost(logic [mckj_pkg::HEIGHT_W-1:0] h, logic last);
      int unsigned   k;
      int unsigned   span;
      int unsigned   idx;
      longint unsigned best;
      longint unsigned diff;
      longint unsigned cand;
      climb_result_t exp_r;
      k = (reach == 0) ? 1 : ((reach > WINDOW) ? WINDOW : int'(reach));
      span = (steps_in_run < k) ? steps_in_run : k;
      best = 0;
      if (span > 0) begin
        best = COST_LIMIT;
        for (int j = 1; j <= span; j++) begin
          idx = (ring_ptr + WINDOW - j) % WINDOW;
          diff = (h >= heights[idx]) ? longint'(h - heights[idx]) :
                                       longint'(heights[idx] - h);
          cand = longint'(costs[idx]) + diff;
          if (cand > COST_LIMIT) begin
            cand = COST_LIMIT;
          end
          if (cand < best) begin
            best = cand;
          end
        end
      end
      heights[ring_ptr] = h;
      costs[ring_ptr]   = best[mckj_pkg::COST_W-1:0];
      ring_ptr = (ring_ptr + 1) % WINDOW;
      if (steps_in_run < WINDOW) begin
        steps_in_run++;
      end
      exp_r.min_cost  = best[mckj_pkg::COST_W-1:0];
      exp_r.saturated = (best == COST_LIMIT);
      exp_r.last_res  = last;
      expected_costs.push_back(exp_r);
      // A finished staircase restarts the window at the next step.
      if (last) begin
        steps_in_run = 0;
        ring_ptr     = 0;
      end
    endfunction

    function void check_cost(logic [mckj_pkg::COST_W-1:0] cost, logic sat, logic last);
      climb_result_t exp_r;
      if (expected_costs.size() == 0) begin
        $error("unexpected cost result: min_cost %0d saturated %0b last_res %0b",
               cost, sat, last);
        errors++;
        return;
      end
      exp_r = expected_costs.pop_front();
      results_checked++;
      if (sat) saturated_seen++;
      if (last) staircases_done++;
      if (cost !== exp_r.min_cost) begin
        $error("min_cost mismatch: expected %0d, actual %0d", exp_r.min_cost, cost);
        errors++;
      end
      if (sat !== exp_r.saturated) begin
        $error("saturated mismatch: expected %0b, actual %0b", exp_r.saturated, sat);
        errors++;
      end
      if (last !== exp_r.last_res) begin
        $error("last_res mismatch: expected %0b, actual %0b", exp_r.last_res, last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  mckj_cfg_if cfg_bus ();
  mckj_in_if  step_bus ();
  mckj_out_if cost_bus ();

  min_cost_k_jump_dp uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (step_bus),
    .out_o  (cost_bus)
  );

  climb_cost_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_requests;
  int hold_served;
  int hold_left;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Result side: checks accepted transactions, then decides ready for the next edge.
  always @(posedge clk_i) begin
    if (rst_ni && cost_bus.valid && cost_bus.ready) begin
      sb.check_cost(cost_bus.min_cost, cost_bus.saturated, cost_bus.last_res);
    end
    if (hold_served != hold_requests) begin
      hold_served    <= hold_requests;
      hold_left      <= 300;
      cost_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left      <= hold_left - 1;
      cost_bus.ready <= 1'b0;
    end else begin
      cost_bus.ready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  task automatic send_step(input logic [mckj_pkg::HEIGHT_W-1:0] h, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99, 0) < tx_idle_pct) gap++;
    if (gap > 0) begin
      step_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    step_bus.valid  <= 1'b1;
    step_bus.height <= h;
    step_bus.last   <= last;
    @(posedge clk_i);
    while (!step_bus.ready) @(posedge clk_i);
    sb.predict_climb_cost(h, last);
  endtask

  task automatic write_reach(input logic [mckj_pkg::REACH_W-1:0] k);
    cfg_bus.valid      <= 1'b1;
    cfg_bus.jump_reach <= k;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    sb.set_reach(k);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    step_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Well-formed staircases of random length and shape; the last one may be cut short.
  task automatic run_staircases(input int n_items);
    int left;
    int len;
    int style;
    logic [mckj_pkg::HEIGHT_W-1:0] base;
    logic [mckj_pkg::HEIGHT_W-1:0] h;
    left = n_items;
    while (left > 0) begin
      case ($urandom_range(9, 0))
        0:          len = 1;
        1, 2:       len = $urandom_range(4, 1);
        3, 4, 5, 6: len = $urandom_range(24, 5);
        default:    len = $urandom_range(60, 25);
      endcase
      style = $urandom_range(3, 0);
      base  = 16'($urandom_range(16'hFFFF, 0));
      for (int i = 0; i < len && left > 0; i++) begin
        case (style)
          0:       h = 16'($urandom_range(16'hFFFF, 0));
          1:       h = base ^ 16'($urandom_range(15, 0));
          2:       h = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
          default: h = base + 16'(i * $urandom_range(300, 0));
        endcase
        send_step(h, i == len - 1);
        left--;
      end
    end
  endtask

  initial begin
    logic [mckj_pkg::REACH_W-1:0] seg_reach;
    sb = new();
    rst_ni             = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.jump_reach = '0;
    step_bus.valid     = 1'b0;
    step_bus.height    = '0;
    step_bus.last      = 1'b0;
    cost_bus.ready     = 1'b0;
    hold_requests      = 0;
    hold_served        = 0;
    hold_left          = 0;
    tx_idle_pct        = 29;
    rx_idle_pct        = 82;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed staircases under the reset reach of 2.
    send_step(16'd1234, 1'b1);
    send_step(16'h0000, 1'b0);
    send_step(16'hFFFF, 1'b0);
    send_step(16'h0000, 1'b0);
    send_step(16'hFFFF, 1'b1);
    send_step(16'hFFFF, 1'b0);
    send_step(16'hFFFF, 1'b0);
    send_step(16'hFFFF, 1'b1);
    send_step(16'hAAAA, 1'b0);
    send_step(16'h5555, 1'b0);
    send_step(16'h0001, 1'b0);
    send_step(16'h8000, 1'b0);
    send_step(16'h7FFF, 1'b1);
    send_step(16'h0000, 1'b0);
    send_step(16'h0000, 1'b1);
    send_step(16'hFFFF, 1'b1);
    wait_idle();

    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        tx_idle_pct = 82;
        rx_idle_pct = 29;
      end else if (seg == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (seg)
        0:       seg_reach = 5'd16;
        1:       seg_reach = 5'd0;
        2:       seg_reach = 5'd31;
        3:       seg_reach = 5'($urandom_range(15, 3));
        4:       seg_reach = 5'd17;
        default: seg_reach = 5'($urandom_range(31, 0));
      endcase
      write_reach(seg_reach);
      // The receiver holds off while staircases keep coming, so the block backs up.
      if (seg == 0 || seg == 4) begin
        hold_requests <= hold_requests + 1;
      end
      run_staircases(325);
      wait_idle();
    end
    repeat (30) @(posedge clk_i);

    $display("Checked %0d cost results over %0d finished staircases, %0d of them saturated.",
             sb.results_checked, sb.staircases_done, sb.saturated_seen);
    $display("Reach settings 0, 2, 16, 17, 31 and random ones were used with stalls on both sides.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("min_cost_k_jump_dp verification clean");
    end else begin
      $display("min_cost_k_jump_dp verification failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("min_cost_k_jump_dp verification failed");
    $finish;
  end

endmodule
